// ----- design/bracket_frame_field_splitter_top_defines.svh -----
// assertion macros for the bracket frame field splitter
// used by the top level, expects signals named clock and reset in scope
`ifndef BRACKET_FRAME_FIELD_SPLITTER_TOP_DEFINES_SVH
`define BRACKET_FRAME_FIELD_SPLITTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BFFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BFFS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BFFS_ASSERT(lbl, prop, msg)
`define BFFS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- design/bffs_pkg.sv -----
// shared types and constants of the bracket frame field splitter
// no dependencies
package bffs_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] fidx_type;
   typedef logic [4:0] cpos_type;
   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type REG_START_CHAR = 2'd0;
   localparam csr_idx_type REG_END_CHAR   = 2'd1;
   localparam csr_idx_type REG_SEP_CHAR   = 2'd2;

   localparam byte_type START_CHAR_RST = 8'd91;
   localparam byte_type END_CHAR_RST   = 8'd93;
   localparam byte_type SEP_CHAR_RST   = 8'd44;

endpackage

// ----- design/bffs_if.sv -----
// request and result channel interfaces of the bracket frame field splitter
// depends on bffs_pkg
interface bffs_req_if;
   logic               valid;
   logic               ready;
   bffs_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface bffs_rsp_if;
   logic               valid;
   logic               ready;
   bffs_pkg::fidx_type field_index;
   bffs_pkg::cpos_type char_position;
   bffs_pkg::byte_type char_value;
   logic               field_end;
   logic               overflow;
   logic               last;

   modport source (output valid, output field_index, output char_position,
                   output char_value, output field_end, output overflow,
                   output last, input ready);
   modport sink (input valid, input field_index, input char_position,
                 input char_value, input field_end, input overflow,
                 input last, output ready);
endinterface

// ----- design/bracket_frame_field_splitter_top.sv -----
// An end byte moves the block from idle to S_READ, which reads the payload ram; the first
// result is registered in S_DATA, or in S_FINAL for an empty frame.
// Throughput: one request per cycle while idle; no request is taken during an emission run,
// whose results wait for a free result slot, and which closes with a result from S_FINAL.
// Reset: synchronous, clears frame state, counters and output valid, and restores the
// start, end and separator characters; the payload ram is not cleared.
`include "bracket_frame_field_splitter_top_defines.svh"
module bracket_frame_field_splitter_top #(
   parameter int PAYLOAD_MAX = 63,
   parameter int MAX_FIELDS  = 6,
   parameter int FIELD_CHARS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   bffs_req_if.sink              req_if,
   bffs_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  bffs_pkg::csr_idx_type csr_index,
   input  bffs_pkg::byte_type    csr_wdata
);

   localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
   localparam int AW    = PAYLOAD_MAX > 1 ? $clog2(PAYLOAD_MAX) : 1;
   localparam int FLD_W = $clog2(MAX_FIELDS + 1);
   localparam int POS_W = $clog2(FIELD_CHARS + 1);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_DATA, S_FINAL} state_type;

   // configuration
   bffs_pkg::byte_type start_ff, end_ff, sep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= bffs_pkg::START_CHAR_RST;
         end_ff   <= bffs_pkg::END_CHAR_RST;
         sep_ff   <= bffs_pkg::SEP_CHAR_RST;
      end else if (csr_we) begin
         case (csr_index)
            bffs_pkg::REG_START_CHAR: start_ff <= csr_wdata;
            bffs_pkg::REG_END_CHAR:   end_ff   <= csr_wdata;
            bffs_pkg::REG_SEP_CHAR:   sep_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type          state_ff, state_in;
   logic               in_frame_ff, in_frame_in;
   logic               dropped_ff, dropped_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in, idx_nxt;
   logic [FLD_W-1:0]   fld_ff, fld_in, fld_clamp;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_clamp;
   logic               fld_sat, pos_sat;

   logic               rsp_valid_ff, rsp_valid_in;
   bffs_pkg::fidx_type fidx_ff, fidx_in;
   bffs_pkg::cpos_type cpos_ff, cpos_in;
   bffs_pkg::byte_type cval_ff, cval_in;
   logic               fend_ff, fend_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;

   logic               req_fire, slot_free, is_sep;
   logic               ram_wr_en, ram_rd_en;
   bffs_pkg::byte_type ram_rd_data;
   bffs_pkg::byte_type rx;

   bffs_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (rx),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rx        = req_if.rx_byte;
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire  = req_if.valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign is_sep    = (ram_rd_data == sep_ff);
   assign idx_nxt   = idx_ff + 1'b1;

   assign ram_wr_en = req_fire && in_frame_ff && (rx != start_ff) && (rx != end_ff)
                      && (cnt_ff < CNT_W'(PAYLOAD_MAX));
   assign ram_rd_en = (state_ff == S_READ);

   // counters stop one past the last legal value, which marks saturation
   assign fld_sat   = (fld_ff == FLD_W'(MAX_FIELDS));
   assign pos_sat   = (pos_ff == POS_W'(FIELD_CHARS));
   assign fld_clamp = fld_sat ? FLD_W'(MAX_FIELDS - 1) : fld_ff;
   assign pos_clamp = pos_sat ? POS_W'(FIELD_CHARS - 1) : pos_ff;

   always_comb begin
      state_in     = state_ff;
      in_frame_in  = in_frame_ff;
      dropped_in   = dropped_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      fld_in       = fld_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      fidx_in      = fidx_ff;
      cpos_in      = cpos_ff;
      cval_in      = cval_ff;
      fend_in      = fend_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (rx == start_ff) begin
                  in_frame_in = 1'b1;
                  cnt_in      = '0;
                  dropped_in  = 1'b0;
               end else if (in_frame_ff) begin
                  if (rx == end_ff) begin
                     in_frame_in = 1'b0;
                     idx_in      = '0;
                     fld_in      = '0;
                     pos_in      = '0;
                     state_in    = (cnt_ff == '0) ? S_FINAL : S_READ;
                  end else if (cnt_ff < CNT_W'(PAYLOAD_MAX)) begin
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               fidx_in      = bffs_pkg::fidx_type'(fld_clamp);
               cpos_in      = bffs_pkg::cpos_type'(pos_clamp);
               cval_in      = is_sep ? '0 : ram_rd_data;
               fend_in      = is_sep;
               ovf_in       = dropped_ff || fld_sat || pos_sat;
               last_in      = 1'b0;
               if (is_sep) begin
                  fld_in = fld_sat ? fld_ff : fld_ff + 1'b1;
                  pos_in = '0;
               end else begin
                  pos_in = pos_sat ? pos_ff : pos_ff + 1'b1;
               end
               idx_in   = idx_nxt;
               state_in = (idx_nxt == cnt_ff) ? S_FINAL : S_READ;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               fidx_in      = bffs_pkg::fidx_type'(fld_clamp);
               cpos_in      = bffs_pkg::cpos_type'(pos_clamp);
               cval_in      = '0;
               fend_in      = 1'b1;
               ovf_in       = dropped_ff || fld_sat || pos_sat;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_frame_ff  <= 1'b0;
         dropped_ff   <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         fld_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         dropped_ff   <= dropped_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         fld_ff       <= fld_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fidx_ff <= fidx_in;
      cpos_ff <= cpos_in;
      cval_ff <= cval_in;
      fend_ff <= fend_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.field_index   = fidx_ff;
   assign rsp_if.char_position = cpos_ff;
   assign rsp_if.char_value    = cval_ff;
   assign rsp_if.field_end     = fend_ff;
   assign rsp_if.overflow      = ovf_ff;
   assign rsp_if.last          = last_ff;

   `BFFS_ASSERT_RST(a_reset_idle, reset |=> (state_ff == S_IDLE && !rsp_valid_ff),
                    "reset did not idle the block")
   `BFFS_ASSERT(a_read_in_range, (state_ff == S_READ) |-> (idx_ff < cnt_ff),
                "read index past stored count")
   `BFFS_ASSERT(a_last_is_end, (rsp_valid_ff && last_ff) |-> fend_ff,
                "final result is not a field end")
   `BFFS_ASSERT(a_final_done, (state_ff == S_FINAL && slot_free) |=>
                (state_ff == S_IDLE && rsp_valid_ff && last_ff), "closing result not issued")

endmodule

// ----- design/bffs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bffs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sim/tb.sv -----
// testbench for the bracket frame field splitter: drives framed byte streams, predicts the
// field/character results in step with the requests and checks every result that comes out
// depends on bffs_pkg, bffs_if and bracket_frame_field_splitter_top
`timescale 1ns / 1ps
module tb;
   import bffs_pkg::*;

   localparam int PAYLOAD_DEPTH = 63;
   localparam int MAX_FIELDS    = 6;
   localparam int FIELD_CHARS   = 20;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PCT      = 13;
   localparam int SEP_PCT       = 25;
   localparam csr_idx_type REG_UNUSED = 2'd3;

   typedef struct packed {
      fidx_type field_index;
      cpos_type char_position;
      byte_type char_value;
      logic     field_end;
      logic     overflow;
      logic     last;
   } char_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   csr_idx_type csr_index;
   byte_type    csr_wdata;

   bffs_req_if req_ch ();
   bffs_rsp_if rsp_ch ();

   bracket_frame_field_splitter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted state of the splitter
   byte_type        cfg_start;
   byte_type        cfg_end;
   byte_type        cfg_sep;
   bit              frame_open;
   byte_type        payload_mem [PAYLOAD_DEPTH];
   int              payload_len;
   bit              bytes_dropped;
   char_result_type char_results_q [$];

   int err_count  = 0;
   int bytes_sent = 0;
   bit idle_on;
   int hold_seq;
   int hold_seen  = 0;
   int hold_left  = 0;

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic void push_char_result(int fld, int pos, byte_type ch, logic fend,
                                            logic lst);
      char_result_type r;
      r.overflow = bytes_dropped;
      if (fld > MAX_FIELDS - 1) begin
         fld = MAX_FIELDS - 1;
         r.overflow = 1'b1;
      end
      if (pos > FIELD_CHARS - 1) begin
         pos = FIELD_CHARS - 1;
         r.overflow = 1'b1;
      end
      r.field_index   = fidx_type'(fld);
      r.char_position = cpos_type'(pos);
      r.char_value    = ch;
      r.field_end     = fend;
      r.last          = lst;
      char_results_q.push_back(r);
   endfunction

   function automatic void split_payload();
      int fld;
      int pos;
      fld = 0;
      pos = 0;
      for (int i = 0; i < payload_len; i++) begin
         if (payload_mem[i] == cfg_sep) begin
            push_char_result(fld, pos, 8'h00, 1'b1, 1'b0);
            fld++;
            pos = 0;
         end else begin
            push_char_result(fld, pos, payload_mem[i], 1'b0, 1'b0);
            pos++;
         end
      end
      push_char_result(fld, pos, 8'h00, 1'b1, 1'b1);
   endfunction

   function automatic void parse_byte(byte_type b);
      // start wins over end, and both win over the separator
      if (b == cfg_start) begin
         frame_open    = 1'b1;
         payload_len   = 0;
         bytes_dropped = 1'b0;
      end else if (frame_open) begin
         if (b == cfg_end) begin
            split_payload();
            frame_open = 1'b0;
         end else if (payload_len < PAYLOAD_DEPTH) begin
            payload_mem[payload_len] = b;
            payload_len++;
         end else begin
            bytes_dropped = 1'b1;
         end
      end
   endfunction

   task automatic check_result();
      char_result_type got;
      char_result_type want;
      got.field_index   = rsp_ch.field_index;
      got.char_position = rsp_ch.char_position;
      got.char_value    = rsp_ch.char_value;
      got.field_end     = rsp_ch.field_end;
      got.overflow      = rsp_ch.overflow;
      got.last          = rsp_ch.last;
      if (char_results_q.size() == 0) begin
         report_mismatch("result arrived with nothing pending");
      end else begin
         want = char_results_q.pop_front();
         if (got !== want)
            report_mismatch($sformatf(
               "got idx %0d pos %0d chr %02h end %b ovf %b last %b, want %0d %0d %02h %b %b %b",
               got.field_index, got.char_position, got.char_value, got.field_end,
               got.overflow, got.last, want.field_index, want.char_position,
               want.char_value, want.field_end, want.overflow, want.last));
      end
   endtask

   // follows config writes and accepted requests, checks each accepted result
   always @(posedge clock) begin
      if (reset) begin
         cfg_start     = START_CHAR_RST;
         cfg_end       = END_CHAR_RST;
         cfg_sep       = SEP_CHAR_RST;
         frame_open    = 1'b0;
         payload_len   = 0;
         bytes_dropped = 1'b0;
         char_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START_CHAR: cfg_start = csr_wdata;
               REG_END_CHAR:   cfg_end   = csr_wdata;
               REG_SEP_CHAR:   cfg_sep   = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            parse_byte(req_ch.rx_byte);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_result();
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic send_byte(input byte_type b);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      // let the monitor take the last accepted request first
      @(posedge clock);
      while (char_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input byte_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int len, input int sep_pct, input bit closed);
      byte_type b;
      send_byte(cfg_start);
      repeat (len) begin
         b = byte_type'($urandom_range(255));
         if ($urandom_range(99) < sep_pct)
            b = cfg_sep;
         send_byte(b);
      end
      if (closed)
         send_byte(cfg_end);
   endtask

   task automatic test_default_chars();
      wait_idle();
      // empty frame
      send_byte(START_CHAR_RST);
      send_byte(END_CHAR_RST);
      // bytes outside a frame, end and separator included
      send_byte(8'h78);
      send_byte(END_CHAR_RST);
      send_byte(SEP_CHAR_RST);
      // restart inside an open frame
      send_byte(START_CHAR_RST);
      send_byte(8'h61);
      send_byte(START_CHAR_RST);
      send_byte(8'h62);
      send_byte(SEP_CHAR_RST);
      send_byte(8'h63);
      send_byte(END_CHAR_RST);
      // zero and all-ones bytes as payload
      send_byte(START_CHAR_RST);
      send_byte(8'h00);
      send_byte(SEP_CHAR_RST);
      send_byte(8'hFF);
      send_byte(END_CHAR_RST);
      wait_idle();
   endtask

   task automatic test_char_extremes();
      wait_idle();
      write_reg(REG_START_CHAR, 8'h00);
      write_reg(REG_END_CHAR, 8'h00);
      write_reg(REG_SEP_CHAR, 8'hFF);
      // start equal to end: the second zero reopens the frame
      send_byte(8'h00);
      send_byte(8'h41);
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_idle();
      // separator equal to end: end wins, the stored ff now splits fields
      write_reg(REG_END_CHAR, 8'hFF);
      send_byte(8'h42);
      send_byte(8'hFF);
      send_byte(8'hFF);
      wait_idle();
      // separator equal to start: start wins; index 3 must change nothing
      write_reg(REG_SEP_CHAR, 8'h00);
      write_reg(REG_UNUSED, 8'h41);
      send_byte(8'h00);
      send_byte(8'h43);
      send_byte(8'h00);
      send_byte(8'h44);
      send_byte(8'hFF);
      wait_idle();
   endtask

   task automatic test_long_frames();
      wait_idle();
      write_reg(REG_START_CHAR, START_CHAR_RST);
      write_reg(REG_END_CHAR, END_CHAR_RST);
      write_reg(REG_SEP_CHAR, SEP_CHAR_RST);
      // one byte past the payload size: dropped bytes and saturated position
      send_byte(START_CHAR_RST);
      repeat (64) send_byte(byte_type'($urandom_range(8'h61, 8'h7A)));
      send_byte(END_CHAR_RST);
      // many empty fields: saturated field index
      send_byte(START_CHAR_RST);
      repeat (7) send_byte(SEP_CHAR_RST);
      send_byte(END_CHAR_RST);
      wait_idle();
   endtask

   task automatic test_random_traffic(input byte_type s, input byte_type e, input byte_type p,
                                      input int n_items);
      int first;
      int len;
      wait_idle();
      write_reg(REG_START_CHAR, s);
      write_reg(REG_END_CHAR, e);
      write_reg(REG_SEP_CHAR, p);
      first = bytes_sent;
      while (bytes_sent - first < n_items) begin
         case ($urandom_range(9))
            0: begin
               repeat ($urandom_range(1, 3)) begin
                  case ($urandom_range(2))
                     0: send_byte(cfg_end);
                     1: send_byte(cfg_sep);
                     default: send_byte(byte_type'($urandom_range(255)));
                  endcase
               end
            end
            1: send_frame($urandom_range(0, 4), SEP_PCT, 1'b0);
            default: begin
               len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
               send_frame(len, SEP_PCT, 1'b1);
            end
         endcase
      end
      wait_idle();
   endtask

   task automatic test_back_to_back();
      int first;
      wait_idle();
      idle_on = 1'b0;
      first = bytes_sent;
      while (bytes_sent - first < 10)
         send_frame($urandom_range(0, 4), SEP_PCT, 1'b1);
      wait_idle();
      idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      wait_idle();
      // result side holds off while frames keep coming, so the request side backs up
      hold_seq++;
      repeat (2) send_frame(4, SEP_PCT, 1'b1);
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_we         = 1'b0;
      csr_index      = REG_START_CHAR;
      csr_wdata      = 8'h00;
      idle_on        = 1'b1;
      hold_seq       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_chars();
      test_char_extremes();
      test_long_frames();
      test_random_traffic(START_CHAR_RST, END_CHAR_RST, SEP_CHAR_RST, 8);
      test_random_traffic(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)),
                          byte_type'($urandom_range(255)), 8);
      test_random_traffic(8'hFF, 8'h00, 8'h80, 6);
      test_back_to_back();
      test_output_stall();

      wait_idle();
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/bffs_pkg.sv
design/bffs_if.sv
design/bffs_ram.sv
design/bracket_frame_field_splitter_top.sv
sim/tb.sv
